// File: design/utf8_to_utf16_transcoder_core_macros.svh
// assertion macros shared by the transcoder rtl
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define U8U16_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u8u16 assertion failed");
// expression that must never be true outside reset
`define U8U16_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("u8u16 forbidden condition seen");
`else
`define U8U16_ASSERT(lbl, clk, rst_n, prop)
`define U8U16_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: design/u8u16_pkg.sv
// types and constants shared by the utf-8 to utf-16 transcoder
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
    localparam logic [20:0] PAIR_OFFSET      = 21'h10000;
    localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;

    // what follows the flushed point in a job
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_UNIT,
        TAIL_END
    } t_tail;

    // one classified byte: an optional code point, then an optional unit or end marker
    typedef struct packed {
        logic        has_point;
        logic [20:0] point;
        t_tail       tail;
        logic [15:0] unit;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// File: design/utf8_to_utf16_transcoder_core.sv
// A byte's first code unit goes through the job queue, then the back end's output register.
// Throughput: one byte per cycle while each byte gives at most one unit and the output is not stalled;
// the back end's output register moves one unit per cycle while i_out_ready holds, a byte's units in turn.
// The two-entry job queue lets the front keep taking bytes while the back end drains.
// Reset (synchronous, active low) clears the pending point, the queue and the output valid.
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_core_macros.svh"

module utf8_to_utf16_transcoder_core
    import u8u16_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_data_byte,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic [15:0] o_code_unit,
    output logic        o_unit_valid,
    output logic        o_end_of_string,
    output logic        o_last_of_run,
    output logic        o_out_valid,
    input  logic        i_out_ready
);

    t_queue_status w_status;
    t_job          w_push_job;
    t_job          w_head;
    logic          w_push;
    logic          w_pop;

    // byte classification
    u8u16_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_data_byte    (i_data_byte),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_queue_status (w_status),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    // job queue
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    // unit expansion and output transaction
    u8u16_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_head_valid    (!w_status.empty),
        .o_pop           (w_pop),
        .o_code_unit     (o_code_unit),
        .o_unit_valid    (o_unit_valid),
        .o_end_of_string (o_end_of_string),
        .o_last_of_run   (o_last_of_run),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready)
    );

    // checks
    `U8U16_ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, w_push && w_status.full)
    `U8U16_ASSERT_NEVER(a_pop_when_empty, i_clk, i_rst_n, w_pop && w_status.empty)
    `U8U16_ASSERT(a_run_continues, i_clk, i_rst_n, o_out_valid && !o_last_of_run |=> o_out_valid)
    `U8U16_ASSERT(a_end_marker_shape, i_clk, i_rst_n,
        o_out_valid && o_end_of_string |->
            !o_unit_valid && o_last_of_run && (o_code_unit == 16'h0000))

endmodule

// File: design/u8u16_front.sv
// front end: takes utf-8 bytes, tracks the pending point and emits jobs
`timescale 1ns / 1ps

module u8u16_front
    import u8u16_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_data_byte,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_queue_status i_queue_status,
    output logic          o_push,
    output t_job          o_job
);

    logic [20:0] r_point;
    logic [20:0] n_point;
    logic [1:0]  r_left;
    logic [1:0]  n_left;
    logic [20:0] w_cont_bits;
    logic [20:0] w_merged;
    logic        w_is_cont;
    logic        w_need_push;
    logic        w_accept;
    t_job        w_job;

    assign o_in_ready = !i_queue_status.full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_cont  = (i_data_byte[7:6] == 2'b10);

    // place the continuation payload by the number still expected
    always_comb begin
        case (r_left)
            2'd3:    w_cont_bits = {9'b0, i_data_byte[5:0], 6'b0} << 6;
            2'd2:    w_cont_bits = {9'b0, i_data_byte[5:0], 6'b0};
            default: w_cont_bits = {15'b0, i_data_byte[5:0]};
        endcase
    end

    assign w_merged = r_point | w_cont_bits;

    // classify the byte and form the job
    always_comb begin
        n_point      = r_point;
        n_left       = r_left;
        w_job        = '0;
        w_job.tail   = TAIL_NONE;
        w_need_push  = 1'b0;
        if ((r_left != 2'd0) && w_is_cont) begin
            n_left = r_left - 2'd1;
            if (r_left == 2'd1) begin
                w_job.has_point = 1'b1;
                w_job.point     = w_merged;
                w_need_push     = 1'b1;
                n_point         = '0;
            end else begin
                n_point = w_merged;
            end
        end else begin
            // flush any partial point ahead of this byte
            w_job.has_point = (r_left != 2'd0);
            w_job.point     = r_point;
            n_point         = '0;
            n_left          = 2'd0;
            if (i_data_byte == 8'h00) begin
                w_job.tail = TAIL_END;
            end else if (!i_data_byte[7]) begin
                w_job.tail = TAIL_UNIT;
                w_job.unit = {8'b0, i_data_byte};
            end else if (i_data_byte[7:5] == 3'b110) begin
                n_point = {10'b0, i_data_byte[4:0], 6'b0};
                n_left  = 2'd1;
            end else if (i_data_byte[7:4] == 4'b1110) begin
                n_point = {5'b0, i_data_byte[3:0], 12'b0};
                n_left  = 2'd2;
            end else if (i_data_byte[7:3] == 5'b11110) begin
                n_point = {i_data_byte[2:0], 18'b0};
                n_left  = 2'd3;
            end else begin
                w_job.tail = TAIL_UNIT;
                w_job.unit = REPLACEMENT_UNIT;
            end
            w_need_push = w_job.has_point || (w_job.tail != TAIL_NONE);
        end
    end

    assign o_push = w_accept && w_need_push;
    assign o_job  = w_job;

    // pending sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point <= '0;
            r_left  <= 2'd0;
        end else if (w_accept) begin
            r_point <= n_point;
            r_left  <= n_left;
        end
    end

endmodule

// File: design/u8u16_queue.sv
// short job queue between the front and back ends
`timescale 1ns / 1ps

module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_head,
    output t_queue_status o_status
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CW'(DEPTH));
    assign o_status.empty  = (r_count == '0);

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: design/u8u16_back.sv
// back end: expands each job into utf-16 code units, one per cycle while the output is not stalled
`timescale 1ns / 1ps

module u8u16_back
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_head_valid,
    output logic        o_pop,
    output logic [15:0] o_code_unit,
    output logic        o_unit_valid,
    output logic        o_end_of_string,
    output logic        o_last_of_run,
    output logic        o_out_valid,
    input  logic        i_out_ready
);

    logic [1:0]  r_step;
    logic [15:0] r_code_unit;
    logic        r_unit_valid;
    logic        r_end;
    logic        r_last;
    logic        r_valid;

    logic [20:0] w_offset;
    logic        w_pair;
    logic [15:0] w_high;
    logic [15:0] w_low;
    logic [1:0]  w_point_units;
    logic [1:0]  w_total_units;
    logic [15:0] w_unit;
    logic        w_unit_valid;
    logic        w_end;
    logic        w_last;
    logic        w_load;

    // surrogate split of the point
    assign w_offset = i_head.point - PAIR_OFFSET;
    assign w_pair   = (i_head.point >= PAIR_OFFSET);
    assign w_high   = HIGH_SURR_BASE + {5'b0, w_offset[20:10]};
    assign w_low    = LOW_SURR_BASE | {6'b0, w_offset[9:0]};

    // number of units this job yields
    always_comb begin
        if (!i_head.has_point) begin
            w_point_units = 2'd0;
        end else if (w_pair) begin
            w_point_units = 2'd2;
        end else begin
            w_point_units = 2'd1;
        end
        w_total_units = w_point_units + {1'b0, (i_head.tail != TAIL_NONE)};
    end

    // select the unit for the current step
    always_comb begin
        w_unit       = '0;
        w_unit_valid = 1'b0;
        w_end        = 1'b0;
        if (r_step < w_point_units) begin
            w_unit_valid = 1'b1;
            if (w_pair) begin
                w_unit = (r_step == 2'd0) ? w_high : w_low;
            end else begin
                w_unit = i_head.point[15:0];
            end
        end else begin
            case (i_head.tail)
                TAIL_UNIT: begin
                    w_unit       = i_head.unit;
                    w_unit_valid = 1'b1;
                end
                TAIL_END: begin
                    w_end = 1'b1;
                end
                default: begin
                    w_unit = '0;
                end
            endcase
        end
    end

    assign w_last = (r_step == w_total_units - 2'd1);
    assign w_load = i_head_valid && (!r_valid || i_out_ready);
    assign o_pop  = w_load && w_last;

    // step through the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_step  <= w_last ? 2'd0 : r_step + 2'd1;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_code_unit  <= w_unit;
            r_unit_valid <= w_unit_valid;
            r_end        <= w_end;
            r_last       <= w_last;
        end
    end

    assign o_code_unit     = r_code_unit;
    assign o_unit_valid    = r_unit_valid;
    assign o_end_of_string = r_end;
    assign o_last_of_run   = r_last;
    assign o_out_valid     = r_valid;

endmodule

// File: tb/utf8_to_utf16_transcoder_core_tb.sv
// self-checking testbench for the utf-8 to utf-16 transcoder core
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_core_tb
    import u8u16_pkg::*;
();

    // utf-8 byte class tags, matched against the top bits of a byte
    localparam logic [7:0] TERMINATOR = 8'h00;
    localparam logic [1:0] CONT_TAG   = 2'b10;
    localparam logic [2:0] LEAD2_TAG  = 3'b110;
    localparam logic [3:0] LEAD3_TAG  = 4'b1110;
    localparam logic [4:0] LEAD4_TAG  = 5'b11110;

    // one utf-16 output transaction as the block should give it
    typedef struct packed {
        logic [15:0] unit;
        logic        valid;
        logic        eos;
        logic        last;
    } t_unit_rec;

    // decoder model plus the queue of code units still owed by the block
    class utf16_scoreboard;
        t_unit_rec   expected_units[$];
        t_unit_rec   run_buf[3];
        int          run_len;
        logic [20:0] partial_point;
        logic [1:0]  conts_left;
        int          errors;
        int          units_checked;
        int          markers_checked;
        int          pairs_seen;
        int          replacements_seen;

        function new();
            partial_point     = '0;
            conts_left        = '0;
            run_len           = 0;
            errors            = 0;
            units_checked     = 0;
            markers_checked   = 0;
            pairs_seen        = 0;
            replacements_seen = 0;
        endfunction

        function void add_rec(logic [15:0] unit, logic valid, logic eos);
            run_buf[run_len] = '{unit: unit, valid: valid, eos: eos, last: 1'b0};
            run_len++;
        endfunction

        // a code point becomes one unit or a surrogate pair
        function void emit_point(logic [20:0] cp);
            logic [20:0] v;
            logic [15:0] hi;
            logic [15:0] lo;
            if (cp >= PAIR_OFFSET) begin
                v  = cp - PAIR_OFFSET;
                hi = HIGH_SURR_BASE + {5'b0, v[20:10]};
                lo = LOW_SURR_BASE + {6'b0, v[9:0]};
                add_rec(hi, 1'b1, 1'b0);
                add_rec(lo, 1'b1, 1'b0);
                pairs_seen++;
            end else begin
                add_rec(cp[15:0], 1'b1, 1'b0);
            end
        endfunction

        // mark the final unit of this byte and queue the run
        function void commit_run();
            int k;
            if (run_len > 0)
                run_buf[run_len - 1].last = 1'b1;
            for (k = 0; k < run_len; k++)
                expected_units.push_back(run_buf[k]);
        endfunction

        // work out the units caused by one accepted byte
        function void note_byte(logic [7:0] b);
            int sh;
            run_len = 0;
            if (conts_left != 0) begin
                if (b[7:6] == CONT_TAG) begin
                    sh            = 6 * (conts_left - 1);
                    partial_point = partial_point | ({15'b0, b[5:0]} << sh);
                    conts_left    = conts_left - 2'd1;
                    if (conts_left == 0) begin
                        emit_point(partial_point);
                        partial_point = '0;
                    end
                    commit_run();
                    return;
                end
                // sequence cut short: flush what was gathered
                emit_point(partial_point);
                partial_point = '0;
                conts_left    = '0;
            end
            if (b == TERMINATOR) begin
                add_rec(16'h0000, 1'b0, 1'b1);
            end else if (!b[7]) begin
                emit_point({13'b0, b});
            end else if (b[7:5] == LEAD2_TAG) begin
                partial_point = {10'b0, b[4:0], 6'b0};
                conts_left    = 2'd1;
            end else if (b[7:4] == LEAD3_TAG) begin
                partial_point = {5'b0, b[3:0], 12'b0};
                conts_left    = 2'd2;
            end else if (b[7:3] == LEAD4_TAG) begin
                partial_point = {b[2:0], 18'b0};
                conts_left    = 2'd3;
            end else begin
                emit_point({5'b0, REPLACEMENT_UNIT});
                replacements_seen++;
            end
            commit_run();
        endfunction

        // compare one output transaction with the oldest expectation
        function void check_unit(logic [15:0] unit, logic valid, logic eos, logic last);
            t_unit_rec exp_rec;
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected unit %h valid %b eos %b last %b",
                         $time, unit, valid, eos, last);
                errors++;
                return;
            end
            exp_rec = expected_units.pop_front();
            if (unit !== exp_rec.unit) begin
                $display("%0t: code_unit expected %h actual %h", $time, exp_rec.unit, unit);
                errors++;
            end
            if (valid !== exp_rec.valid) begin
                $display("%0t: unit_valid expected %b actual %b", $time, exp_rec.valid, valid);
                errors++;
            end
            if (eos !== exp_rec.eos) begin
                $display("%0t: end_of_string expected %b actual %b", $time, exp_rec.eos, eos);
                errors++;
            end
            if (last !== exp_rec.last) begin
                $display("%0t: last_of_run expected %b actual %b", $time, exp_rec.last, last);
                errors++;
            end
            if (exp_rec.eos)
                markers_checked++;
            else
                units_checked++;
        endfunction

        function int outstanding();
            return expected_units.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_in_valid  = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic [15:0] o_code_unit;
    logic        o_unit_valid;
    logic        o_end_of_string;
    logic        o_last_of_run;
    logic        o_out_valid;

    utf16_scoreboard sb;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int bytes_sent   = 0;

    // extremes, every byte class and the malformed cases
    logic [7:0] directed_bytes [25] = '{
        8'h7F,                          // top of ascii
        8'hC3, 8'hA9,                   // two-byte point
        8'hE2, 8'h82, 8'hAC,            // three-byte point
        8'hF0, 8'h9F, 8'h98, 8'h80,     // four-byte point, surrogate pair
        8'h80,                          // stray continuation
        8'hFF,                          // invalid lead
        8'hC0, 8'h80,                   // overlong form
        8'hE0, 8'h41,                   // sequence cut by ascii
        8'hF7, 8'hBF, 8'hBF, 8'hBF,     // largest point, truncated pair
        8'hF4, 8'h00,                   // bare lead flushed by terminator
        8'hC2, 8'hF8,                   // lead cut by invalid lead
        8'h00                           // empty string
    };

    utf8_to_utf16_transcoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_data_byte     (i_data_byte),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .o_code_unit     (o_code_unit),
        .o_unit_valid    (o_unit_valid),
        .o_end_of_string (o_end_of_string),
        .o_last_of_run   (o_last_of_run),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready)
    );

    always #4 i_clk = ~i_clk;

    // output side: check each transaction, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_unit(o_code_unit, o_unit_valid, o_end_of_string, o_last_of_run);
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // present one byte, holding it until the transaction completes
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // hold off the input until every owed unit has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    function automatic logic [7:0] rand_cont();
        return {CONT_TAG, 6'($urandom_range(0, 63))};
    endfunction

    // mostly well-formed characters, some terminators, cut sequences and noise
    task automatic send_random_chunk();
        int r;
        int nconts;
        int k;
        r = $urandom_range(99);
        if (r < 25) begin
            send_byte(8'($urandom_range(1, 127)));
        end else if (r < 45) begin
            send_byte({LEAD2_TAG, 5'($urandom_range(0, 31))});
            send_byte(rand_cont());
        end else if (r < 65) begin
            send_byte({LEAD3_TAG, 4'($urandom_range(0, 15))});
            for (k = 0; k < 2; k++)
                send_byte(rand_cont());
        end else if (r < 80) begin
            send_byte({LEAD4_TAG, 3'($urandom_range(0, 7))});
            for (k = 0; k < 3; k++)
                send_byte(rand_cont());
        end else if (r < 87) begin
            send_byte(TERMINATOR);
        end else if (r < 93) begin
            nconts = $urandom_range(1, 3);
            case (nconts)
                1: send_byte({LEAD2_TAG, 5'($urandom_range(0, 31))});
                2: send_byte({LEAD3_TAG, 4'($urandom_range(0, 15))});
                default: send_byte({LEAD4_TAG, 3'($urandom_range(0, 7))});
            endcase
            for (k = $urandom_range(0, nconts - 1); k > 0; k--)
                send_byte(rand_cont());
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int target);
        while (bytes_sent < target)
            send_random_chunk();
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // slow receiver
        snd_idle_pct = 11;
        rcv_idle_pct = 63;
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        wait_drained();
        run_random(120);
        wait_drained();

        // slow sender
        snd_idle_pct = 63;
        rcv_idle_pct = 11;
        run_random(240);
        wait_drained();

        // full rate on both sides
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(360);
        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("sent %0d bytes; checked %0d code units and %0d end markers",
                 bytes_sent, sb.units_checked, sb.markers_checked);
        $display("including %0d surrogate pairs and %0d replacement units, %0d errors",
                 sb.pairs_seen, sb.replacements_seen, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/u8u16_pkg.sv
design/u8u16_front.sv
design/u8u16_queue.sv
design/u8u16_back.sv
design/utf8_to_utf16_transcoder_core.sv
tb/utf8_to_utf16_transcoder_core_tb.sv
